FILE: hdl/eup_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eup_pkg
// Shared types, constants and helpers of the EEG packet unpacker.
// ----------------------------------------------------------------------------
package eup_pkg;

  localparam int MSG_LEN  = 20;
  localparam int NCH      = 4;
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 33;
  localparam int PROD_W   = 66;
  localparam int RND_W    = PROD_W - 32;
  localparam int CHAN_W   = 28;

  localparam logic [CNT_W-1:0] COUNT_MAX   = 5'd31;
  localparam logic [CNT_W-1:0] CNT_MSG_END = 5'd19;
  localparam logic [CNT_W-1:0] CNT_BAT_END = 5'd3;
  localparam logic [CNT_W-1:0] CNT_MSG_LEN = 5'd20;
  localparam logic [31:0]      GAIN_RESET  = 32'd204800195;

  // Four channel values in output order T3, T4, O1, O2.
  typedef logic [NCH-1:0][VAL_W-1:0] val4_t;

  // One decoded message: base values and delta-corrected values.
  typedef struct packed {
    logic [10:0] counter;
    logic [7:0]  battery;
    val4_t       base;
    val4_t       corr;
  } snap_t;

  // One item handed to the scaler.
  typedef struct packed {
    logic [10:0] counter;
    logic [7:0]  battery;
    logic        last;
    val4_t       vals;
  } job_t;

  // Clamp a rounded product to the signed channel range.
  function automatic logic [CHAN_W-1:0] sat_chan(input logic signed [RND_W-1:0] r);
    logic signed [RND_W-1:0] hi;
    logic signed [RND_W-1:0] lo;
    hi = RND_W'(134217727);
    lo = -RND_W'(134217728);
    if (r > hi) begin
      sat_chan = hi[CHAN_W-1:0];
    end else if (r < lo) begin
      sat_chan = lo[CHAN_W-1:0];
    end else begin
      sat_chan = r[CHAN_W-1:0];
    end
  endfunction

endpackage

FILE: hdl/eup_msg_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eup_msg_buffer
// Collects message bytes, tracks the length and battery level, and decodes a
// finished 20-byte message in the cycle after its last byte.
// ----------------------------------------------------------------------------
module eup_msg_buffer import eup_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  output logic       at_last,
  output logic       snap_valid,
  output snap_t      snap
);

  logic [7:0]       msg_bytes [MSG_LEN];
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic [7:0]       battery_byte;
  logic             done;

  logic [NCH-1:0][31:0] word;
  logic [NCH-1:0][15:0] delta;

  assign at_last = (byte_count == CNT_MSG_END);

  always_comb begin
    byte_count_next = byte_count;
    if (end_of_message) begin
      byte_count_next = '0;
    end else if (byte_count != COUNT_MAX) begin
      byte_count_next = byte_count + 1'b1;
    end
  end

  // Byte store has no reset; a full message writes every byte before use.
  always_ff @(posedge clk) begin
    if (wr_en && (byte_count < CNT_MSG_LEN)) begin
      msg_bytes[byte_count] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count   <= '0;
      battery_byte <= '0;
      done         <= 1'b0;
    end else begin
      done <= wr_en && end_of_message && (byte_count == CNT_MSG_END);
      if (wr_en) begin
        byte_count <= byte_count_next;
        if (end_of_message && (byte_count == CNT_BAT_END)) begin
          battery_byte <= msg_bytes[2];
        end
      end
    end
  end

  // Words in output order T3, T4, O1, O2 are message words 2, 3, 1 and 4.
  assign word[0] = {msg_bytes[4][6:0], msg_bytes[5], msg_bytes[6], msg_bytes[7], 1'b0};
  assign word[1] = {msg_bytes[6][1:0], msg_bytes[7], msg_bytes[8], msg_bytes[9], 6'b0};
  assign word[2] = {msg_bytes[1][3:0], msg_bytes[2], msg_bytes[3], msg_bytes[4], 4'b0};
  assign word[3] = {msg_bytes[9][4:0], msg_bytes[10], msg_bytes[11], 11'b0};

  assign delta[0] = {msg_bytes[14], msg_bytes[15]};
  assign delta[1] = {msg_bytes[16], msg_bytes[17]};
  assign delta[2] = {msg_bytes[12], msg_bytes[13]};
  assign delta[3] = {msg_bytes[18], msg_bytes[19]};

  always_comb begin
    snap.counter = {msg_bytes[0], msg_bytes[1][7:5]};
    snap.battery = battery_byte;
    for (int j = 0; j < NCH; j++) begin
      snap.base[j] = {word[j][31], word[j]};
      snap.corr[j] = {word[j][31], word[j]} + {{6{delta[j][15]}}, delta[j], 11'b0};
    end
  end

  assign snap_valid = done;

endmodule

FILE: hdl/eup_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eup_scaler
// Multiplies four channel values by the gain, rounds, saturates and holds
// the result word until it is taken.
// ----------------------------------------------------------------------------
module eup_scaler import eup_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        gain,
  input  logic               job_valid,
  input  job_t               job,
  output logic               job_ready,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [10:0]        counter,
  output logic [7:0]         battery,
  output logic               last,
  output logic [NCH-1:0][CHAN_W-1:0] chans
);

  logic                          prod_valid;
  logic signed [PROD_W-1:0]      prod [NCH];
  logic [10:0]                   prod_counter;
  logic [7:0]                    prod_battery;
  logic                          prod_last;
  logic                          out_load;
  logic signed [PROD_W-1:0]      rnd_sum [NCH];

  assign out_load  = prod_valid && (!out_valid || !out_stall);
  assign job_ready = !prod_valid || out_load;
  assign busy      = prod_valid || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (job_ready) begin
        prod_valid <= job_valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      for (int j = 0; j < NCH; j++) begin
        prod[j] <= PROD_W'($signed(job.vals[j]) * $signed({1'b0, gain}));
      end
      prod_counter <= job.counter;
      prod_battery <= job.battery;
      prod_last    <= job.last;
    end
  end

  always_comb begin
    for (int j = 0; j < NCH; j++) begin
      rnd_sum[j] = prod[j] + PROD_W'(64'h8000_0000);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int j = 0; j < NCH; j++) begin
        chans[j] <= sat_chan(rnd_sum[j][PROD_W-1:32]);
      end
      counter <= prod_counter;
      battery <= prod_battery;
      last    <= prod_last;
    end
  end

endmodule

FILE: hdl/eeg_packet_unpacker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eeg_packet_unpacker_unit
// Unpacks radio notifications of an EEG headband into scaled channel words.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake            Payload
//   -------  -------------------  ---------------------------------------------
//   in       in_valid / in_stall  data_byte, end_of_message
//   out      out_valid/out_stall  sample_counter, chan_t3..chan_o2,
//                                 battery_percent, pair_last
//   config   APB (psel..pready)   gain at byte address 0
//
// One byte word is accepted per cycle while the input does not stall. A 20-byte
// message gives two result words, the base one first, then the corrected one;
// each passes the pair register and the product and output registers of the scaler.
// Input stalls only on the twentieth byte of a message while the results of
// the previous message still sit in the decode, pair or scaling registers.
// Reset is synchronous; it clears the byte count, battery level and all valid
// flags and loads the default gain. A stalled output word holds until taken.
// ----------------------------------------------------------------------------
module eeg_packet_unpacker_unit import eup_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // byte input
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               data_byte,
  input  logic                     end_of_message,
  // sample output
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [10:0]              sample_counter,
  output logic signed [CHAN_W-1:0] chan_t3,
  output logic signed [CHAN_W-1:0] chan_t4,
  output logic signed [CHAN_W-1:0] chan_o1,
  output logic signed [CHAN_W-1:0] chan_o2,
  output logic [7:0]               battery_percent,
  output logic                     pair_last,
  // configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic [2:0] GAIN_ADDR = 3'd0;

  logic        gain;
  logic [31:0] gain_reg;
  logic        in_accept;
  logic        at_last;
  logic        snap_valid;
  snap_t       snap;
  snap_t       pair_snap;
  logic [1:0]  pend;
  logic [1:0]  pend_next;
  job_t        job;
  logic        job_ready;
  logic        scaler_busy;
  logic        busy;
  logic [NCH-1:0][CHAN_W-1:0] chans;

  // Configuration: a single gain register, always ready.
  assign pready = 1'b1;
  assign gain   = psel && penable && pwrite && (paddr == GAIN_ADDR);
  assign prdata = (paddr == GAIN_ADDR) ? gain_reg : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_reg <= GAIN_RESET;
    end else if (gain) begin
      gain_reg <= pwdata;
    end
  end

  // The decoder must be free before a message can finish, so the closing
  // byte is held back while earlier results are still in flight.
  assign busy      = snap_valid || (pend != 2'b00) || scaler_busy;
  assign in_stall  = at_last && busy;
  assign in_accept = in_valid && !in_stall;

  eup_msg_buffer u_buf (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (in_accept),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .at_last        (at_last),
    .snap_valid     (snap_valid),
    .snap           (snap)
  );

  // Pair register: the base word goes out first, then the corrected one.
  always_comb begin
    job.counter = pair_snap.counter;
    job.battery = pair_snap.battery;
    job.last    = !pend[0];
    job.vals    = pend[0] ? pair_snap.base : pair_snap.corr;
  end

  always_comb begin
    pend_next = pend;
    if (snap_valid) begin
      pend_next = 2'b11;
    end else if (job_ready && (pend != 2'b00)) begin
      if (pend[0]) begin
        pend_next = 2'b10;
      end else begin
        pend_next = 2'b00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 2'b00;
    end else begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid) begin
      pair_snap <= snap;
    end
  end

  eup_scaler u_scaler (
    .clk       (clk),
    .rst       (rst),
    .gain      (gain_reg),
    .job_valid (pend != 2'b00),
    .job       (job),
    .job_ready (job_ready),
    .busy      (scaler_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .counter   (sample_counter),
    .battery   (battery_percent),
    .last      (pair_last),
    .chans     (chans)
  );

  assign chan_t3 = chans[0];
  assign chan_t4 = chans[1];
  assign chan_o1 = chans[2];
  assign chan_o2 = chans[3];

endmodule

FILE: tb/tb_eeg_packet_unpacker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eeg_packet_unpacker_unit
// Self-checking bench for the EEG packet unpacker: drives notification bytes,
// rebuilds the scaled channel samples from its own unpacker, and compares them.
// ----------------------------------------------------------------------------
//
// The run opens with a short table of directed notifications. These cover
// all-zero and all-one words, the counter at its top value, battery updates,
// lengths next to the valid ones, an overlong notification that saturates the
// byte count, and the gain at zero, one and full scale. Each row either has
// its result typed in or is checked against the predictor. Random phases then
// follow, one per gain setting. They are mostly well-formed 20-byte and
// 4-byte notifications with random content, mixed with notifications of random
// length. Both sides insert random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_eeg_packet_unpacker_unit;
  import eup_pkg::*;

  localparam int          CLK_PERIOD  = 8;
  localparam int          RST_CYCLES  = 7;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          IDLE_LAT    = 12;   // cycles to let the pipeline empty
  localparam int          PHASE_BYTES = 160;
  localparam int          BAT_LEN     = 4;
  localparam int          MAX_REPORTS = 10;
  localparam logic [2:0]  GAIN_ADDR   = 3'd0;
  localparam longint      CH_MAX      = 134217727;
  localparam longint      CH_MIN      = -134217728;

  // One output word of the block.
  typedef struct packed {
    logic [10:0]       counter;
    logic [CHAN_W-1:0] t3;
    logic [CHAN_W-1:0] t4;
    logic [CHAN_W-1:0] o1;
    logic [CHAN_W-1:0] o2;
    logic [7:0]        battery;
    logic              last;
  } sample_t;

  typedef enum logic [1:0] {ROW_MSG, ROW_GAIN} row_kind_t;

  // One row of the directed table. A message row sends len bytes: b0, b1 and
  // b2 at the first three positions, fill everywhere else. Rows with typed set
  // carry their expected counter, channel value (all four) and battery level.
  typedef struct {
    row_kind_t   kind;
    int          len;
    logic [31:0] gain;
    logic [7:0]  fill;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    bit          typed;
    logic [10:0] e_cnt;
    logic [27:0] e_chan;
    logic [7:0]  e_bat;
  } stim_row_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Block ports. All inputs start at known values.
  logic                     in_valid       = 1'b0;
  logic                     in_stall;
  logic [7:0]               data_byte      = 8'h00;
  logic                     end_of_message = 1'b0;
  logic                     out_valid;
  logic                     out_stall      = 1'b0;
  logic [10:0]              sample_counter;
  logic signed [CHAN_W-1:0] chan_t3;
  logic signed [CHAN_W-1:0] chan_t4;
  logic signed [CHAN_W-1:0] chan_o1;
  logic signed [CHAN_W-1:0] chan_o2;
  logic [7:0]               battery_percent;
  logic                     pair_last;
  logic                     psel           = 1'b0;
  logic                     penable        = 1'b0;
  logic                     pwrite         = 1'b0;
  logic [2:0]               paddr          = 3'd0;
  logic [31:0]              pwdata         = 32'h0;
  logic [31:0]              prdata;
  logic                     pready;

  eeg_packet_unpacker_unit i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .data_byte       (data_byte),
    .end_of_message  (end_of_message),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sample_counter  (sample_counter),
    .chan_t3         (chan_t3),
    .chan_t4         (chan_t4),
    .chan_o1         (chan_o1),
    .chan_o2         (chan_o2),
    .battery_percent (battery_percent),
    .pair_last       (pair_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Predictor state: its own copy of the message buffer, byte count, battery
  // level and gain. The buffer starts undefined, as in the block; a 20-byte
  // message always overwrites every entry before it is decoded.
  logic [7:0]  frame_buf [MSG_LEN];
  logic [4:0]  frame_len   = '0;
  logic [7:0]  battery_lvl = 8'h00;
  logic [31:0] gain_q      = GAIN_RESET;

  // Expected output words, oldest first.
  sample_t pending_samples [$];

  // When the directed row being sent has typed results, they replace the
  // predicted ones for the 20-byte message it forms.
  bit          row_typed = 1'b0;
  logic [10:0] row_cnt;
  logic [27:0] row_chan;
  logic [7:0]  row_bat;

  // No gaps between bytes of the current notification when set.
  bit gap_free = 1'b0;

  int fail_cnt     = 0;
  int bytes_sent   = 0;
  int msgs_seen    = 0;
  int words_seen   = 0;
  int gain_writes  = 0;
  int cycle_cnt    = 0;
  int stall_left   = 0;

  stim_row_t   dir_rows [26];
  logic [31:0] phase_gain [6];

  // Scale a channel value in 1/2048 count to 1/256 microvolt: multiply by the
  // gain, round half toward plus infinity at bit 32, clamp to 28 bits.
  function automatic logic [CHAN_W-1:0] scale_to_uv(input longint x);
    logic [95:0] mag;
    logic [95:0] acc;
    longint      r;
    mag = (x < 0) ? 96'(-x) : 96'(x);
    if (x < 0) begin
      acc = (mag * {64'd0, gain_q} + 96'h7FFF_FFFF) >> 32;
      r = acc[62:0];
      r = -r;
    end else begin
      acc = (mag * {64'd0, gain_q} + 96'h8000_0000) >> 32;
      r = acc[62:0];
    end
    if (r > CH_MAX) r = CH_MAX;
    if (r < CH_MIN) r = CH_MIN;
    return r[CHAN_W-1:0];
  endfunction

  // Take one accepted byte into the predictor. At the end of a notification,
  // a 4-byte one updates the battery level, and a 20-byte one queues its two
  // output words. Any other length is dropped.
  task automatic unpack_byte(input logic [7:0] b, input logic eom);
    logic [4:0]  len;
    logic [31:0] w [4];
    logic [15:0] dw;
    longint      base [4];
    longint      dlt [4];
    longint      v [4];
    logic [10:0] cnt;
    sample_t     s;
    if (frame_len < MSG_LEN) frame_buf[frame_len] = b;
    if (frame_len < COUNT_MAX) frame_len = frame_len + 5'd1;
    if (eom) begin
      len = frame_len;
      frame_len = '0;
      msgs_seen++;
      if (len == BAT_LEN) begin
        battery_lvl = frame_buf[2];
      end else if (len == CNT_MSG_LEN) begin
        cnt  = {frame_buf[0], frame_buf[1][7:5]};
        // The four channel words sit at unaligned bit offsets across bytes 1..11.
        w[0] = {frame_buf[1][3:0], frame_buf[2], frame_buf[3], frame_buf[4], 4'h0};
        w[1] = {frame_buf[4][6:0], frame_buf[5], frame_buf[6], frame_buf[7], 1'b0};
        w[2] = {frame_buf[6][1:0], frame_buf[7], frame_buf[8], frame_buf[9], 6'h0};
        w[3] = {frame_buf[9][4:0], frame_buf[10], frame_buf[11], 11'h0};
        for (int j = 0; j < 4; j++) begin
          base[j] = longint'($signed(w[j]));
          dw      = {frame_buf[12 + 2 * j], frame_buf[13 + 2 * j]};
          dlt[j]  = longint'($signed(dw));
        end
        for (int k = 0; k < 2; k++) begin
          for (int j = 0; j < 4; j++) begin
            v[j] = base[j] + ((k != 0) ? dlt[j] * 2048 : 0);
          end
          s.counter = cnt;
          s.t3      = scale_to_uv(v[1]);
          s.t4      = scale_to_uv(v[2]);
          s.o1      = scale_to_uv(v[0]);
          s.o2      = scale_to_uv(v[3]);
          s.battery = battery_lvl;
          s.last    = (k != 0);
          if (row_typed) begin
            s.counter = row_cnt;
            s.t3      = row_chan;
            s.t4      = row_chan;
            s.o1      = row_chan;
            s.o2      = row_chan;
            s.battery = row_bat;
          end
          pending_samples = {pending_samples, s};
        end
      end
    end
  endtask

  // Compare one accepted output word with the oldest expectation.
  task automatic check_sample();
    sample_t got;
    sample_t want;
    got = '{sample_counter, chan_t3, chan_t4, chan_o1, chan_o2, battery_percent, pair_last};
    words_seen++;
    if (pending_samples.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: unexpected output word: cnt=%0d last=%0d", $realtime, got.counter,
                 got.last);
    end else begin
      want = pending_samples.pop_front();
      if (got.counter !== want.counter || got.t3 !== want.t3 || got.t4 !== want.t4 ||
          got.o1 !== want.o1 || got.o2 !== want.o2 || got.battery !== want.battery ||
          got.last !== want.last) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS) begin
          $display("%0t: word mismatch, expected cnt=%0d t3=%0d t4=%0d o1=%0d o2=%0d bat=%0d last=%0d",
                   $realtime, want.counter, $signed(want.t3), $signed(want.t4),
                   $signed(want.o1), $signed(want.o2), want.battery, want.last);
          $display("%0t:                 actual cnt=%0d t3=%0d t4=%0d o1=%0d o2=%0d bat=%0d last=%0d",
                   $realtime, got.counter, $signed(got.t3), $signed(got.t4),
                   $signed(got.o1), $signed(got.o2), got.battery, got.last);
        end
      end
    end
  endtask

  // Both channels are sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) check_sample();
      if (in_valid && !in_stall) unpack_byte(data_byte, end_of_message);
    end
  end

  // Output stall pattern: runs of ready cycles, short stalls, and now and then
  // a long stall. Some runs are long enough to give stretches with no stall.
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(0, 6);
        end
        4: begin
          out_stall  <= 1'b0;
          stall_left <= $urandom_range(30, 120);
        end
        5, 6, 7, 8: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(0, 3);
        end
        default: begin
          out_stall  <= 1'b1;
          stall_left <= $urandom_range(10, 40);
        end
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding", cycle_cnt,
               pending_samples.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one byte word. Called just after a falling edge, and returns just
  // after the falling edge that follows its acceptance. A gap lowers valid
  // first; without a gap valid simply stays high for the next word.
  task automatic put_byte(input logic [7:0] b, input logic eom);
    int gap;
    int r;
    gap = 0;
    if (!gap_free) begin
      r = $urandom_range(0, 99);
      if (r < 65) gap = 0;
      else if (r < 93) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    @(negedge clk);
  endtask

  // Stop sending and wait until the block holds no more work. A notification
  // with no result may still be in flight, so an idle tail of IDLE_LAT follows.
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (IDLE_LAT) @(negedge clk);
  endtask

  // Write the gain register over the configuration port, then read it back.
  task automatic write_gain(input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAIN_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    gain_q = value;
    gain_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: gain readback expected %h actual %h", $realtime, value, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte(input bit biased);
    if (biased && $urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'hFF;
        2:       return 8'h7F;
        default: return 8'h80;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int          len;
    int          r;
    int          sent;
    bit          biased;
    logic [7:0]  b;

    // Directed notifications. The first rows run with the gain at its reset
    // value and the battery level still zero.
    //            kind      len gain            fill   b0     b1     b2     typ  cnt
    //                                                                          chan   bat
    dir_rows[0]  = '{ROW_MSG, 20, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 11'd0, 28'd0, 8'd0};
    dir_rows[1]  = '{ROW_MSG, 20, 32'h0, 8'h00, 8'hFF, 8'hE0, 8'h00,
                     1'b1, 11'd2047, 28'd0, 8'd0};
    // Battery notifications at both extremes, each seen by the next message.
    dir_rows[2]  = '{ROW_MSG, 4, 32'h0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[3]  = '{ROW_MSG, 20, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00,
                     1'b1, 11'd0, 28'd0, 8'd255};
    dir_rows[4]  = '{ROW_MSG, 4, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[5]  = '{ROW_MSG, 20, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[6]  = '{ROW_MSG, 20, 32'h0, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[7]  = '{ROW_MSG, 20, 32'h0, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0, 11'd0, 28'd0, 8'd0};
    // Lengths that must be dropped, including one that saturates the count.
    dir_rows[8]  = '{ROW_MSG, 1, 32'h0, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[9]  = '{ROW_MSG, 19, 32'h0, 8'h55, 8'h55, 8'h55, 8'h55, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[10] = '{ROW_MSG, 21, 32'h0, 8'h55, 8'h55, 8'h55, 8'h55, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[11] = '{ROW_MSG, 3, 32'h0, 8'h33, 8'h33, 8'h33, 8'hEE, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[12] = '{ROW_MSG, 5, 32'h0, 8'h33, 8'h33, 8'h33, 8'hEE, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[13] = '{ROW_MSG, 33, 32'h0, 8'hC3, 8'hC3, 8'hC3, 8'hC3, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[14] = '{ROW_MSG, 20, 32'h0, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 1'b0, 11'd0, 28'd0, 8'd0};
    // Full-scale gain drives the 0x80 and 0x7F patterns into saturation.
    dir_rows[15] = '{ROW_GAIN, 0, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00,
                     1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[16] = '{ROW_MSG, 20, 32'h0, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[17] = '{ROW_MSG, 20, 32'h0, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[18] = '{ROW_MSG, 20, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 11'd0, 28'd0, 8'd0};
    // Zero gain gives zero on every channel.
    dir_rows[19] = '{ROW_GAIN, 0, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[20] = '{ROW_MSG, 20, 32'h0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     1'b1, 11'd2047, 28'd0, 8'd0};
    // The smallest nonzero gain exercises the rounding on small products.
    dir_rows[21] = '{ROW_GAIN, 0, 32'h1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[22] = '{ROW_MSG, 20, 32'h0, 8'h80, 8'h80, 8'h80, 8'h80, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[23] = '{ROW_GAIN, 0, GAIN_RESET, 8'h00, 8'h00, 8'h00, 8'h00,
                     1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[24] = '{ROW_MSG, 4, 32'h0, 8'h00, 8'h00, 8'h00, 8'h5A, 1'b0, 11'd0, 28'd0, 8'd0};
    dir_rows[25] = '{ROW_MSG, 20, 32'h0, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 1'b0, 11'd0, 28'd0, 8'd0};

    // Gain settings of the random phases, extremes among them.
    phase_gain[0] = GAIN_RESET;
    phase_gain[1] = $urandom();
    phase_gain[2] = 32'hFFFF_FFFF;
    phase_gain[3] = $urandom_range(0, 1 << 20);
    phase_gain[4] = 32'h0;
    phase_gain[5] = $urandom();

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: walk the table.
    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_GAIN) begin
        settle_idle();
        write_gain(dir_rows[n].gain);
      end else begin
        row_typed = dir_rows[n].typed;
        row_cnt   = dir_rows[n].e_cnt;
        row_chan  = dir_rows[n].e_chan;
        row_bat   = dir_rows[n].e_bat;
        gap_free  = ($urandom_range(0, 1) == 0);
        for (int i = 0; i < dir_rows[n].len; i++) begin
          if (i == 0) b = dir_rows[n].b0;
          else if (i == 1) b = dir_rows[n].b1;
          else if (i == 2) b = dir_rows[n].b2;
          else b = dir_rows[n].fill;
          put_byte(b, i == dir_rows[n].len - 1);
        end
        row_typed = 1'b0;
      end
    end

    // Random phases. Three notifications in four are 20-byte samples and one in
    // ten is a battery notification; the rest are random lengths that may merge or cut short.
    foreach (phase_gain[p]) begin
      settle_idle();
      write_gain(phase_gain[p]);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        r = $urandom_range(0, 99);
        if (r < 75) len = MSG_LEN;
        else if (r < 85) len = BAT_LEN;
        else len = $urandom_range(1, 40);
        biased   = ($urandom_range(0, 3) == 0);
        gap_free = ($urandom_range(0, 9) < 3);
        for (int i = 0; i < len; i++) put_byte(pick_byte(biased), i == len - 1);
        sent += len;
      end
    end

    // Drain: every expected word must come out, then a quiet tail follows so
    // that a stray word would still be caught.
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (IDLE_LAT * 2) @(negedge clk);
    if (pending_samples.size() != 0) fail_cnt += pending_samples.size();

    $display("Sent %0d bytes in %0d notifications under %0d gain writes.", bytes_sent,
             msgs_seen, gain_writes);
    $display("Compared %0d sample words; %0d failures.", words_seen, fail_cnt);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
